/* hw/rtl/frm_pkg.sv */
package frm_pkg;

  // default sizes
  localparam int FRM_DEPTH     = 16;
  localparam int FRM_WORD_BITS = 32;

  // width of the occupancy result field
  localparam int FRM_OCC_BITS  = 5;

  // request operation codes
  localparam logic FRM_OP_PUSH = 1'b0;
  localparam logic FRM_OP_POP  = 1'b1;

  // per-cycle command broadcast along a chain of cells
  typedef struct packed {
    logic load;   // a word enters the chain this cycle
    logic shift;  // every cell takes its right neighbor's word
  } frm_ctrl_t;

endpackage

/* hw/rtl/frm_word_cell.sv */
module frm_word_cell
  import frm_pkg::*;
#(
  parameter int WORD_BITS = FRM_WORD_BITS
) (
  input  logic                        clk_i,
  input  frm_ctrl_t                   ctrl_i,
  input  logic                        sel_i,
  input  logic signed [WORD_BITS-1:0] word_i,
  input  logic signed [WORD_BITS-1:0] next_word_i,
  output logic signed [WORD_BITS-1:0] word_o
);

  logic signed [WORD_BITS-1:0] word_q;
  logic signed [WORD_BITS-1:0] word_d;

  // shift toward the head on pop, capture at the tail slot on push
  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift) begin
      word_d = next_word_i;
    end else if (ctrl_i.load && sel_i) begin
      word_d = word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* hw/rtl/frm_cand_cell.sv */
module frm_cand_cell
  import frm_pkg::*;
#(
  parameter int WORD_BITS = FRM_WORD_BITS
) (
  input  logic                        clk_i,
  input  frm_ctrl_t                   ctrl_i,
  input  logic                        live_i,
  input  logic                        prev_keep_i,
  input  logic signed [WORD_BITS-1:0] word_i,
  input  logic signed [WORD_BITS-1:0] next_val_i,
  output logic                        keep_o,
  output logic signed [WORD_BITS-1:0] val_o
);

  logic signed [WORD_BITS-1:0] val_q;
  logic signed [WORD_BITS-1:0] val_d;

  // a live candidate survives a push unless it is strictly smaller
  assign keep_o = live_i && !(val_q < word_i);

  // first dropped slot takes the pushed word, head match shifts left
  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      if (!keep_o && prev_keep_i) begin
        val_d = word_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* hw/rtl/fifo_with_running_maximum_unit.sv */
// A request accepted at a clock edge gives its result strobe in the next cycle.
// Throughput: one push or pop per cycle; busy_o never rises, since every cell of
//   both chains updates in parallel and the receiver cannot stall.
// Reset (rst_ni low, asynchronous): queue and candidate list emptied, no strobe.
//   Stored words need no clearing; only occupied cells are ever read.
module fifo_with_running_maximum_unit
  import frm_pkg::*;
#(
  parameter int DEPTH     = FRM_DEPTH,
  parameter int WORD_BITS = FRM_WORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        mode_i,
  input  logic signed [WORD_BITS-1:0] value_i,
  output logic                        valid_o,
  output logic signed [WORD_BITS-1:0] popped_word_o,
  output logic                        pop_on_empty_o,
  output logic                        push_dropped_o,
  output logic signed [WORD_BITS-1:0] current_max_o,
  output logic                        max_valid_o,
  output logic [FRM_OCC_BITS-1:0]     occupancy_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [CNT_W-1:0] word_cnt_q, word_cnt_d;
  logic [CNT_W-1:0] cand_cnt_q, cand_cnt_d;

  logic                        valid_q;
  logic signed [WORD_BITS-1:0] popped_q, popped_d;
  logic                        empty_q, empty_d;
  logic                        drop_q, drop_d;

  logic is_push, is_pop, do_push, do_pop, pop_match;
  frm_ctrl_t word_ctrl, cand_ctrl;

  logic signed [WORD_BITS-1:0] wcell [DEPTH];
  logic signed [WORD_BITS-1:0] ccell [DEPTH];
  logic [DEPTH-1:0]            keep;
  logic [DEPTH-1:0]            prev_keep;
  logic [DEPTH-1:0]            live;
  logic [DEPTH-1:0]            bnd;
  logic [IDX_W-1:0]            bnd_idx;
  logic [CNT_W+FRM_OCC_BITS-1:0] occ_ext;

  // every request is taken in the cycle it is offered
  assign busy_o  = 1'b0;
  assign is_push = start_i && (mode_i == FRM_OP_PUSH);
  assign is_pop  = start_i && (mode_i == FRM_OP_POP);
  assign do_push = is_push && (word_cnt_q != CNT_W'(DEPTH));
  assign do_pop  = is_pop && (word_cnt_q != '0);

  // head candidate leaves with the word that matches it
  assign pop_match = do_pop && (cand_cnt_q != '0) && (ccell[0] == wcell[0]);

  assign word_ctrl = '{load: do_push, shift: do_pop};
  assign cand_ctrl = '{load: do_push, shift: pop_match};

  // queue chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_word
    logic signed [WORD_BITS-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = wcell[i+1];
    end
    frm_word_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (word_ctrl),
      .sel_i      (word_cnt_q == CNT_W'(i)),
      .word_i     (value_i),
      .next_word_i(nxt),
      .word_o     (wcell[i])
    );
  end

  // candidate chain, non-increasing from the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cand
    logic signed [WORD_BITS-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ccell[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_keep[i] = 1'b1;
    end else begin : g_tail
      assign prev_keep[i] = keep[i-1];
    end
    assign live[i] = CNT_W'(i) < cand_cnt_q;
    assign bnd[i]  = prev_keep[i] && !keep[i];
    frm_cand_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cand_ctrl),
      .live_i     (live[i]),
      .prev_keep_i(prev_keep[i]),
      .word_i     (value_i),
      .next_val_i (nxt),
      .keep_o     (keep[i]),
      .val_o      (ccell[i])
    );
  end

  // position where the pushed word lands (one-hot to binary)
  always_comb begin
    bnd_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bnd[i]) begin
        bnd_idx = bnd_idx | IDX_W'(i);
      end
    end
  end

  // counters
  always_comb begin
    word_cnt_d = word_cnt_q;
    cand_cnt_d = cand_cnt_q;
    if (do_push) begin
      word_cnt_d = word_cnt_q + CNT_W'(1);
      cand_cnt_d = CNT_W'(bnd_idx) + CNT_W'(1);
    end else if (do_pop) begin
      word_cnt_d = word_cnt_q - CNT_W'(1);
      if (pop_match) begin
        cand_cnt_d = cand_cnt_q - CNT_W'(1);
      end
    end
  end

  // result fields of the request
  always_comb begin
    popped_d = do_pop ? wcell[0] : '0;
    empty_d  = is_pop && (word_cnt_q == '0);
    drop_d   = is_push && (word_cnt_q == CNT_W'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt_q <= '0;
      cand_cnt_q <= '0;
      valid_q    <= 1'b0;
      empty_q    <= 1'b0;
      drop_q     <= 1'b0;
    end else begin
      word_cnt_q <= word_cnt_d;
      cand_cnt_q <= cand_cnt_d;
      valid_q    <= start_i;
      empty_q    <= empty_d;
      drop_q     <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
  end

  // outputs reflect the state left by the last request
  assign occ_ext        = (CNT_W + FRM_OCC_BITS)'(word_cnt_q);
  assign valid_o        = valid_q;
  assign popped_word_o  = popped_q;
  assign pop_on_empty_o = empty_q;
  assign push_dropped_o = drop_q;
  assign max_valid_o    = (word_cnt_q != '0);
  assign current_max_o  = (word_cnt_q != '0) ? ccell[0] : '0;
  assign occupancy_o    = occ_ext[FRM_OCC_BITS-1:0];

`ifndef SYNTH
  a_cand_le_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_cnt_q <= word_cnt_q)
    else $error("candidate count exceeds word count");

  a_cand_when_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_cnt_q != '0) |-> (cand_cnt_q != '0))
    else $error("non-empty queue without a maximum candidate");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(pop_on_empty_o && push_dropped_o))
    else $error("pop and push error flags together");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_pop && (word_cnt_q != '0)) |=> (word_cnt_q == $past(word_cnt_q) - CNT_W'(1)))
    else $error("pop did not lower the occupancy");
`endif

endmodule

/* dv/frm_checker.sv */
module frm_checker
  import frm_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            mode_i,
  input  logic signed [FRM_WORD_BITS-1:0] value_i,
  input  logic                            valid_i,
  input  logic signed [FRM_WORD_BITS-1:0] popped_word_i,
  input  logic                            pop_on_empty_i,
  input  logic                            push_dropped_i,
  input  logic signed [FRM_WORD_BITS-1:0] current_max_i,
  input  logic                            max_valid_i,
  input  logic [FRM_OCC_BITS-1:0]         occupancy_i,
  output int                              mismatch_count_o,
  output int                              outstanding_o
);

  localparam int PEND_DEPTH = 8;

  typedef logic signed [FRM_WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t                   popped_word;
    logic                    pop_on_empty;
    logic                    push_dropped;
    word_t                   current_max;
    logic                    max_valid;
    logic [FRM_OCC_BITS-1:0] occupancy;
  } queue_status_t;

  // shadow ring of the queue and the non-increasing candidate list
  word_t         shadow_words[FRM_DEPTH];
  int            shadow_head;
  int            shadow_count;
  word_t         cand_words[FRM_DEPTH];
  int            cand_count;

  // predicted results waiting for their strobe
  queue_status_t pending[PEND_DEPTH];
  int            pend_head;
  int            pend_count;

  // apply one accepted request to the shadow state and queue its status
  task automatic predict_status(input logic op, input word_t word);
    queue_status_t st;
    st = '0;
    if (op == FRM_OP_PUSH) begin
      if (shadow_count >= FRM_DEPTH) begin
        st.push_dropped = 1'b1;
      end else begin
        shadow_words[(shadow_head + shadow_count) % FRM_DEPTH] = word;
        shadow_count++;
        // smaller candidates at the back can never be the maximum again
        while (cand_count > 0 && cand_words[cand_count-1] < word)
          cand_count--;
        if (cand_count < FRM_DEPTH) begin
          cand_words[cand_count] = word;
          cand_count++;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        st.pop_on_empty = 1'b1;
      end else begin
        st.popped_word = shadow_words[shadow_head];
        shadow_head = (shadow_head + 1) % FRM_DEPTH;
        shadow_count--;
        if (cand_count > 0 && cand_words[0] == st.popped_word) begin
          for (int i = 1; i < cand_count; i++)
            cand_words[i-1] = cand_words[i];
          cand_count--;
        end
      end
    end
    st.max_valid = (shadow_count > 0);
    if (st.max_valid && cand_count > 0)
      st.current_max = cand_words[0];
    st.occupancy = FRM_OCC_BITS'(shadow_count);
    if (pend_count >= PEND_DEPTH) begin
      $error("too many requests outstanding");
      mismatch_count_o++;
    end else begin
      pending[(pend_head + pend_count) % PEND_DEPTH] = st;
      pend_count++;
    end
  endtask

  // compare one strobed result with the oldest prediction
  task automatic compare_status();
    queue_status_t exp;
    if (pend_count == 0) begin
      $error("result strobe with no request outstanding");
      mismatch_count_o++;
    end else begin
      exp = pending[pend_head];
      pend_head = (pend_head + 1) % PEND_DEPTH;
      pend_count--;
      if (popped_word_i !== exp.popped_word) begin
        $error("popped_word: expected %0d, got %0d", exp.popped_word, popped_word_i);
        mismatch_count_o++;
      end
      if (pop_on_empty_i !== exp.pop_on_empty) begin
        $error("pop_on_empty: expected %0d, got %0d", exp.pop_on_empty, pop_on_empty_i);
        mismatch_count_o++;
      end
      if (push_dropped_i !== exp.push_dropped) begin
        $error("push_dropped: expected %0d, got %0d", exp.push_dropped, push_dropped_i);
        mismatch_count_o++;
      end
      if (current_max_i !== exp.current_max) begin
        $error("current_max: expected %0d, got %0d", exp.current_max, current_max_i);
        mismatch_count_o++;
      end
      if (max_valid_i !== exp.max_valid) begin
        $error("max_valid: expected %0d, got %0d", exp.max_valid, max_valid_i);
        mismatch_count_o++;
      end
      if (occupancy_i !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy_i);
        mismatch_count_o++;
      end
    end
  endtask

  // predict on request, then check any strobe at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_head      = 0;
      shadow_count     = 0;
      cand_count       = 0;
      pend_head        = 0;
      pend_count       = 0;
      outstanding_o    = 0;
      mismatch_count_o = 0;
    end else begin
      if (start_i && !busy_i)
        predict_status(mode_i, value_i);
      if (valid_i)
        compare_status();
      outstanding_o = pend_count;
    end
  end

endmodule

/* dv/testbench.sv */
module testbench;
  import frm_pkg::*;

  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_TAIL      = 100;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic                            mode;
  logic signed [FRM_WORD_BITS-1:0] value;
  logic                            valid;
  logic signed [FRM_WORD_BITS-1:0] popped_word;
  logic                            pop_on_empty;
  logic                            push_dropped;
  logic signed [FRM_WORD_BITS-1:0] current_max;
  logic                            max_valid;
  logic [FRM_OCC_BITS-1:0]         occupancy;
  int                              mismatch_count;
  int                              outstanding;

  fifo_with_running_maximum_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .mode_i         (mode),
    .value_i        (value),
    .valid_o        (valid),
    .popped_word_o  (popped_word),
    .pop_on_empty_o (pop_on_empty),
    .push_dropped_o (push_dropped),
    .current_max_o  (current_max),
    .max_valid_o    (max_valid),
    .occupancy_o    (occupancy)
  );

  frm_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .mode_i           (mode),
    .value_i          (value),
    .valid_i          (valid),
    .popped_word_i    (popped_word),
    .pop_on_empty_i   (pop_on_empty),
    .push_dropped_i   (push_dropped),
    .current_max_i    (current_max),
    .max_valid_i      (max_valid),
    .occupancy_i      (occupancy),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  // issue one request and hold it until it is taken
  task automatic send_request(input logic op, input logic signed [FRM_WORD_BITS-1:0] word);
    logic busy_seen;
    start <= 1'b1;
    mode  <= op;
    value <= word;
    forever begin
      @(negedge clk);
      busy_seen = busy;
      @(posedge clk);
      if (!busy_seen) break;
    end
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    value <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // pop carries a random ignored value
  task automatic send_pop();
    send_request(FRM_OP_POP, $urandom);
  endtask

  // small values for ties in 4 of 10 picks, extremes in 1, full range in the rest
  function automatic logic signed [FRM_WORD_BITS-1:0] pick_word();
    logic signed [FRM_WORD_BITS-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = $signed($urandom_range(0, 6)) - 3;
      4: begin
        case ($urandom_range(0, 3))
          0: w = {1'b0, {(FRM_WORD_BITS-1){1'b1}}};
          1: w = {1'b1, {(FRM_WORD_BITS-1){1'b0}}};
          2: w = '1;
          default: w = '0;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  initial begin
    int push_pct;
    int idle_on;
    rst_n = 1'b0;
    start = 1'b0;
    mode  = FRM_OP_PUSH;
    value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, extremes, equal maxima, full queue, four pops
    send_pop();
    send_request(FRM_OP_PUSH, {1'b0, {(FRM_WORD_BITS-1){1'b1}}});
    send_request(FRM_OP_PUSH, {1'b1, {(FRM_WORD_BITS-1){1'b0}}});
    send_pop();
    send_request(FRM_OP_PUSH, 5);
    send_request(FRM_OP_PUSH, 5);
    send_request(FRM_OP_PUSH, -1);
    for (int i = 0; i < 12; i++)
      send_request(FRM_OP_PUSH, (i % 3 == 0) ? 5 : i - 6);
    send_request(FRM_OP_PUSH, 100);
    for (int i = 0; i < 4; i++)
      send_pop();
    idle_cycles(1);
    wait (outstanding == 0);
    @(posedge clk);

    // random traffic in segments of varying push bias
    push_pct = 50;
    idle_on  = 1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 10;
          1: push_pct = 35;
          2: push_pct = 50;
          3: push_pct = 70;
          default: push_pct = 92;
        endcase
        idle_on = $urandom_range(0, 2);
      end
      // let everything drain once mid-run
      if (n == RANDOM_REQUESTS / 2) begin
        idle_cycles(1);
        wait (outstanding == 0);
        @(posedge clk);
      end
      if (idle_on != 0 && n < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 16));
      if ($urandom_range(1, 100) <= push_pct)
        send_request(FRM_OP_PUSH, pick_word());
      else
        send_pop();
    end
    start <= 1'b0;

    // drain and settle
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
